FILE: rtl/core/tgc_pkg.sv
`timescale 1ns / 1ps

package tgc_pkg;

  localparam int POS_BITS_DEF  = 12;
  localparam int TIME_BITS_DEF = 32;
  localparam int MS_W          = 16;
  localparam int CFG_IDX_W     = 2;
  localparam int OUT_W         = 8;

  localparam int SWIPE_MIN_RESET = 1229;
  localparam int TAP_MOVE_RESET  = 410;
  localparam int TAP_MS_RESET    = 200;
  localparam int DTAP_MS_RESET   = 400;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SWIPE_MIN = 2'd0,
    REG_TAP_MOVE  = 2'd1,
    REG_TAP_MS    = 2'd2,
    REG_DTAP_MS   = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    GEST_NONE   = 3'd0,
    GEST_TAP    = 3'd1,
    GEST_DOUBLE = 3'd2,
    GEST_LEFT   = 3'd3,
    GEST_RIGHT  = 3'd4,
    GEST_UP     = 3'd5,
    GEST_DOWN   = 3'd6
  } gesture_t;

  typedef struct packed {
    logic     lift;
    logic     swipe;
    logic     tap;
    gesture_t dir;
  } stroke_t;

endpackage

FILE: rtl/core/tgc_cfg.sv
`timescale 1ns / 1ps

module tgc_cfg #(
  parameter int POS_BITS = tgc_pkg::POS_BITS_DEF,
  parameter int CFG_W    = tgc_pkg::MS_W,
  localparam int SQ_W    = 2 * POS_BITS + 2
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [tgc_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]             cfg_wdata,
  output logic [SQ_W-1:0]              swipe_sq,
  output logic [SQ_W-1:0]              tap_sq,
  output logic [tgc_pkg::MS_W-1:0]     tap_max_ms,
  output logic [tgc_pkg::MS_W-1:0]     double_tap_ms
);
  import tgc_pkg::*;

  localparam logic [POS_BITS:0] SWIPE_RST = (POS_BITS + 1)'(SWIPE_MIN_RESET);
  localparam logic [POS_BITS:0] MOVE_RST  = (POS_BITS + 1)'(TAP_MOVE_RESET);
  localparam logic [SQ_W-1:0] SWIPE_SQ_RST = SQ_W'(SWIPE_RST) * SQ_W'(SWIPE_RST);
  localparam logic [SQ_W-1:0] MOVE_SQ_RST  = SQ_W'(MOVE_RST) * SQ_W'(MOVE_RST);

  logic [POS_BITS:0] wr_dist;
  logic [SQ_W-1:0]   wr_sq;

  // distance thresholds are kept squared so the datapath never takes a root
  assign wr_dist = cfg_wdata[POS_BITS:0];
  assign wr_sq   = SQ_W'(wr_dist) * SQ_W'(wr_dist);

  always_ff @(posedge clk) begin
    if (rst) begin
      swipe_sq      <= SWIPE_SQ_RST;
      tap_sq        <= MOVE_SQ_RST;
      tap_max_ms    <= MS_W'(TAP_MS_RESET);
      double_tap_ms <= MS_W'(DTAP_MS_RESET);
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        REG_SWIPE_MIN: swipe_sq      <= wr_sq;
        REG_TAP_MOVE:  tap_sq        <= wr_sq;
        REG_TAP_MS:    tap_max_ms    <= cfg_wdata[MS_W-1:0];
        REG_DTAP_MS:   double_tap_ms <= cfg_wdata[MS_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/core/tgc_stroke.sv
`timescale 1ns / 1ps

module tgc_stroke #(
  parameter int POS_BITS  = tgc_pkg::POS_BITS_DEF,
  parameter int TIME_BITS = tgc_pkg::TIME_BITS_DEF,
  localparam int SQ_W     = 2 * POS_BITS + 2
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     step,
  input  logic                     down,
  input  logic [POS_BITS-1:0]      x,
  input  logic [POS_BITS-1:0]      y,
  input  logic [TIME_BITS-1:0]     t,
  input  logic [SQ_W-1:0]          swipe_sq,
  input  logic [SQ_W-1:0]          tap_sq,
  input  logic [tgc_pkg::MS_W-1:0] tap_max_ms,
  output tgc_pkg::stroke_t         stroke
);
  import tgc_pkg::*;

  logic                  was_touching;
  logic [POS_BITS-1:0]   start_x;
  logic [POS_BITS-1:0]   start_y;
  logic [TIME_BITS-1:0]  start_time;

  logic [POS_BITS:0]     dx, dy, dx_neg, dy_neg;
  logic [POS_BITS-1:0]   ax, ay;
  logic [2*POS_BITS-1:0] ax2, ay2;
  logic [SQ_W-1:0]       d2;
  logic [TIME_BITS-1:0]  duration;
  logic                  press;

  assign press = down && !was_touching;

  always_ff @(posedge clk) begin
    if (rst) begin
      was_touching <= 1'b0;
    end else if (step) begin
      was_touching <= down;
    end
  end

  always_ff @(posedge clk) begin
    if (step && press) begin
      start_x    <= x;
      start_y    <= y;
      start_time <= t;
    end
  end

  assign dx     = {1'b0, x} - {1'b0, start_x};
  assign dy     = {1'b0, y} - {1'b0, start_y};
  assign dx_neg = -dx;
  assign dy_neg = -dy;
  assign ax     = dx[POS_BITS] ? dx_neg[POS_BITS-1:0] : dx[POS_BITS-1:0];
  assign ay     = dy[POS_BITS] ? dy_neg[POS_BITS-1:0] : dy[POS_BITS-1:0];
  assign ax2    = (2 * POS_BITS)'(ax) * (2 * POS_BITS)'(ax);
  assign ay2    = (2 * POS_BITS)'(ay) * (2 * POS_BITS)'(ay);
  assign d2     = SQ_W'(ax2) + SQ_W'(ay2);

  // modulo 2^TIME_BITS, so a wrapped timestamp still gives the right span
  assign duration = t - start_time;

  always_comb begin
    stroke.lift  = !down && was_touching;
    stroke.swipe = (d2 >= swipe_sq);
    stroke.tap   = !stroke.swipe && (d2 < tap_sq) &&
                   (duration <= TIME_BITS'(tap_max_ms));
    if (ax > ay) begin
      stroke.dir = (x > start_x) ? GEST_RIGHT : GEST_LEFT;
    end else begin
      stroke.dir = (y > start_y) ? GEST_DOWN : GEST_UP;
    end
  end

endmodule

FILE: rtl/core/tgc_tap.sv
`timescale 1ns / 1ps

module tgc_tap #(
  parameter int TIME_BITS = tgc_pkg::TIME_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     step,
  input  logic [TIME_BITS-1:0]     t,
  input  tgc_pkg::stroke_t         stroke,
  input  logic [tgc_pkg::MS_W-1:0] double_tap_ms,
  output tgc_pkg::gesture_t        code
);
  import tgc_pkg::*;

  logic                 tap_armed;
  logic [TIME_BITS-1:0] prev_tap_time;
  logic [TIME_BITS-1:0] gap;
  logic                 is_double;

  assign gap       = t - prev_tap_time;
  assign is_double = tap_armed && (gap <= TIME_BITS'(double_tap_ms));

  always_comb begin
    if (!stroke.lift) begin
      code = GEST_NONE;
    end else if (stroke.swipe) begin
      code = stroke.dir;
    end else if (stroke.tap) begin
      code = is_double ? GEST_DOUBLE : GEST_TAP;
    end else begin
      code = GEST_NONE;
    end
  end

  // a double tap disarms, so a third tap counts as single again
  always_ff @(posedge clk) begin
    if (rst) begin
      tap_armed     <= 1'b0;
      prev_tap_time <= '0;
    end else if (step && stroke.lift && stroke.tap) begin
      tap_armed     <= !is_double;
      prev_tap_time <= is_double ? '0 : t;
    end
  end

  a_double_needs_arm: assert property (@(posedge clk) disable iff (rst)
    (code == GEST_DOUBLE) |-> tap_armed)
    else $error("double tap reported without an earlier tap");

  a_double_disarms: assert property (@(posedge clk) disable iff (rst)
    (step && code == GEST_DOUBLE) |=> !tap_armed)
    else $error("tap memory still armed after double tap");

  a_tap_arms: assert property (@(posedge clk) disable iff (rst)
    (step && code == GEST_TAP) |=> (tap_armed && prev_tap_time == $past(t)))
    else $error("single tap did not arm tap memory");

endmodule

FILE: rtl/core/touch_gesture_classifier_core.sv
`timescale 1ns / 1ps
// channel   | dir | handshake                     | payload
// s_axis    | in  | s_axis_tvalid / s_axis_tready | tdata: finger_down, pos_x, pos_y, now_ms
// m_axis    | out | m_axis_tvalid / m_axis_tready | tdata: gesture
// cfg       | in  | cfg_we (no wait)              | cfg_addr, cfg_wdata
//
// one sample per cycle sustained while results are taken; each sample is held in the input
// register and then moves into the result register once that is free or being taken.
// the whole classification (deltas, one 12x12 square per axis, threshold compares,
// tap memory update) sits between the input and result registers.
// rst is synchronous; it clears both stage valids, touch and tap memory, and
// loads the register defaults. a stalled result holds while a new sample still
// waits in the input register; s_axis_tready drops only when both are full.
module touch_gesture_classifier_core #(
  parameter int  POS_BITS  = tgc_pkg::POS_BITS_DEF,
  parameter int  TIME_BITS = tgc_pkg::TIME_BITS_DEF,
  localparam int IN_W      = ((1 + 2 * POS_BITS + TIME_BITS + 7) / 8) * 8,
  localparam int CFG_W     = (POS_BITS + 1 > tgc_pkg::MS_W) ? POS_BITS + 1 : tgc_pkg::MS_W
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // finger_down, pos_x, pos_y, now_ms from bit 0 up, zero filled
  input  logic [IN_W-1:0]               s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // gesture from bit 0 up, zero filled
  output logic [tgc_pkg::OUT_W-1:0]     m_axis_tdata,
  input  logic                          cfg_we,
  input  logic [tgc_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]              cfg_wdata
);
  import tgc_pkg::*;

  localparam int SQ_W = 2 * POS_BITS + 2;

  logic                 in_valid;
  logic                 in_down;
  logic [POS_BITS-1:0]  in_x;
  logic [POS_BITS-1:0]  in_y;
  logic [TIME_BITS-1:0] in_t;
  logic                 take;
  logic                 adv;

  logic                 out_valid;
  gesture_t             gesture;
  gesture_t             code;

  logic [SQ_W-1:0]      swipe_sq;
  logic [SQ_W-1:0]      tap_sq;
  logic [MS_W-1:0]      tap_max_ms;
  logic [MS_W-1:0]      double_tap_ms;
  stroke_t              stroke;

  assign adv           = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || adv;
  assign take          = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (take) begin
      in_valid <= 1'b1;
    end else if (adv) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      in_down <= s_axis_tdata[0];
      in_x    <= s_axis_tdata[POS_BITS:1];
      in_y    <= s_axis_tdata[2*POS_BITS:POS_BITS+1];
      in_t    <= s_axis_tdata[2*POS_BITS+TIME_BITS:2*POS_BITS+1];
    end
  end

  tgc_cfg #(
    .POS_BITS (POS_BITS),
    .CFG_W    (CFG_W)
  ) u_cfg (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .swipe_sq      (swipe_sq),
    .tap_sq        (tap_sq),
    .tap_max_ms    (tap_max_ms),
    .double_tap_ms (double_tap_ms)
  );

  tgc_stroke #(
    .POS_BITS  (POS_BITS),
    .TIME_BITS (TIME_BITS)
  ) u_stroke (
    .clk        (clk),
    .rst        (rst),
    .step       (adv),
    .down       (in_down),
    .x          (in_x),
    .y          (in_y),
    .t          (in_t),
    .swipe_sq   (swipe_sq),
    .tap_sq     (tap_sq),
    .tap_max_ms (tap_max_ms),
    .stroke     (stroke)
  );

  tgc_tap #(
    .TIME_BITS (TIME_BITS)
  ) u_tap (
    .clk           (clk),
    .rst           (rst),
    .step          (adv),
    .t             (in_t),
    .stroke        (stroke),
    .double_tap_ms (double_tap_ms),
    .code          (code)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      gesture <= code;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(OUT_W - 3){1'b0}}, gesture};

  a_input_held: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !adv) |=> (in_valid && $stable(in_t) && $stable(in_down)))
    else $error("waiting sample lost from input register");

  a_result_from_input: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid))
    else $error("result produced with no sample in input register");

  a_only_lift_reports: assert property (@(posedge clk) disable iff (rst)
    (adv && !stroke.lift) |=> (gesture == GEST_NONE))
    else $error("gesture reported on a sample that is no release");

endmodule

FILE: test/touch_gesture_classifier_core_tb.sv
`timescale 1ns / 1ps

module touch_gesture_classifier_core_tb;
  import tgc_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 267;
  localparam int PROBE_N = 27;

  typedef struct packed {
    logic        down;
    logic [11:0] x;
    logic [11:0] y;
    logic [31:0] t;
    logic        typed;
    gesture_t    want;
  } probe_row_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        cfg_we = 1'b0;
  cfg_reg_t    cfg_addr = REG_SWIPE_MIN;
  logic [15:0] cfg_wdata = '0;

  // register shadow
  logic [12:0] cfg_swipe = 13'(SWIPE_MIN_RESET);
  logic [12:0] cfg_move = 13'(TAP_MOVE_RESET);
  logic [15:0] cfg_tap_ms = 16'(TAP_MS_RESET);
  logic [15:0] cfg_dtap = 16'(DTAP_MS_RESET);

  // touch and tap memory shadow
  logic        touching = 1'b0;
  logic [11:0] press_x = '0;
  logic [11:0] press_y = '0;
  logic [31:0] press_ms = '0;
  logic [31:0] last_tap_ms = '0;
  logic        tap_pending = 1'b0;

  gesture_t    gesture_q[$];
  int          gest_seen[7];
  int          n_sent = 0;
  int          n_random = 0;
  int          errors = 0;
  int unsigned cycles = 0;
  int          src_idle_pct = 8;
  int          dst_idle_pct = 82;
  logic [31:0] now_ms = 32'd100;
  probe_row_t  probe_rows[PROBE_N];

  touch_gesture_classifier_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic gesture_t predict_gesture(logic down, logic [11:0] x, logic [11:0] y,
                                               logic [31:0] t);
    int          dx, dy;
    longint      ax, ay, d2;
    logic [31:0] held, gap;
    gesture_t    g;
    g = GEST_NONE;
    if (down && !touching) begin
      press_x = x;
      press_y = y;
      press_ms = t;
    end
    if (!down && touching) begin
      dx = int'(x) - int'(press_x);
      dy = int'(y) - int'(press_y);
      ax = longint'((dx < 0) ? -dx : dx);
      ay = longint'((dy < 0) ? -dy : dy);
      d2 = ax * ax + ay * ay;
      held = t - press_ms;
      if (d2 >= longint'(cfg_swipe) * longint'(cfg_swipe)) begin
        if (ax > ay) g = (dx > 0) ? GEST_RIGHT : GEST_LEFT;
        else g = (dy > 0) ? GEST_DOWN : GEST_UP;
      end else if (held <= 32'(cfg_tap_ms) && d2 < longint'(cfg_move) * longint'(cfg_move)) begin
        gap = t - last_tap_ms;
        if (tap_pending && gap <= 32'(cfg_dtap)) begin
          tap_pending = 1'b0;
          last_tap_ms = '0;
          g = GEST_DOUBLE;
        end else begin
          tap_pending = 1'b1;
          last_tap_ms = t;
          g = GEST_TAP;
        end
      end
    end
    touching = down;
    return g;
  endfunction

  // one touch sample request; the expectation is queued as soon as it is taken
  task automatic send_sample(input logic down, input int x, input int y, input logic [31:0] t,
                             input logic typed = 1'b0, input gesture_t want = GEST_NONE);
    gesture_t g;
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {7'b0, t, 12'(y), 12'(x), down};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    g = predict_gesture(down, 12'(x), 12'(y), t);
    if (typed) g = want;
    gesture_q.push_back(g);
    gest_seen[int'(g)]++;
    n_sent++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (gesture_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_regs(input logic [15:0] swipe, input logic [15:0] move,
                            input logic [15:0] tap_ms, input logic [15:0] dtap_ms);
    cfg_we <= 1'b1;
    cfg_addr <= REG_SWIPE_MIN;
    cfg_wdata <= swipe;
    @(posedge clk);
    cfg_addr <= REG_TAP_MOVE;
    cfg_wdata <= move;
    @(posedge clk);
    cfg_addr <= REG_TAP_MS;
    cfg_wdata <= tap_ms;
    @(posedge clk);
    cfg_addr <= REG_DTAP_MS;
    cfg_wdata <= dtap_ms;
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_swipe = swipe[12:0];
    cfg_move = move[12:0];
    cfg_tap_ms = tap_ms;
    cfg_dtap = dtap_ms;
  endtask

  // release end point: random direction, turned back if it leaves the pad
  function automatic int end_pos(int s, int d);
    int e;
    if ($urandom_range(1)) d = -d;
    if (s + d > 4095 || s + d < 0) d = -d;
    e = s + d;
    if (e < 0) e = 0;
    if (e > 4095) e = 4095;
    return e;
  endfunction

  // press, a few hold samples, release inside, near or beyond the tap and swipe bounds, then idle samples
  task automatic play_stroke();
    int          sx, sy, ax, ay, ex, ey, tmp, nhold, k;
    int unsigned dur;
    logic [31:0] t0;
    now_ms = now_ms + $urandom_range(int'(cfg_dtap) / 2 + 4);
    if ($urandom_range(40) == 0) now_ms = 32'hFFFF_FFFF - $urandom_range(int'(cfg_tap_ms));
    t0 = now_ms;
    sx = $urandom_range(4095);
    sy = $urandom_range(4095);
    case ($urandom_range(5))
      0: dur = 32'(cfg_tap_ms);
      1: dur = cfg_tap_ms + 1;
      default: dur = $urandom_range(int'(cfg_tap_ms) + int'(cfg_tap_ms) / 4 + 2);
    endcase
    ay = 0;
    case ($urandom_range(7))
      0, 1, 2: begin
        ax = $urandom_range(int'(cfg_move)) * 7 / 10;
        ay = $urandom_range(int'(cfg_move)) * 7 / 10;
      end
      3: ax = int'(cfg_move) - $urandom_range(1);
      4: ax = int'(cfg_swipe) - $urandom_range(1);
      5: begin
        ax = $urandom_range(int'(cfg_swipe));
        ay = ax;
      end
      default: begin
        ax = $urandom_range(4095);
        ay = $urandom_range(4095);
      end
    endcase
    if ($urandom_range(1)) begin
      tmp = ax;
      ax = ay;
      ay = tmp;
    end
    ex = end_pos(sx, ax);
    ey = end_pos(sy, ay);
    send_sample(1'b1, sx, sy, t0);
    nhold = $urandom_range(3);
    for (k = 1; k <= nhold; k++)
      send_sample(1'b1, $urandom_range(4095), $urandom_range(4095), t0 + dur * k / (nhold + 1));
    now_ms = t0 + dur;
    send_sample(1'b0, ex, ey, now_ms);
    for (k = $urandom_range(2); k > 0; k--) begin
      now_ms = now_ms + $urandom_range(20);
      send_sample(1'b0, $urandom_range(4095), $urandom_range(4095), now_ms);
    end
  endtask

  task automatic run_phase(input logic [15:0] swipe, input logic [15:0] move,
                           input logic [15:0] tap_ms, input logic [15:0] dtap_ms);
    int first;
    write_regs(swipe, move, tap_ms, dtap_ms);
    first = n_sent;
    while (n_sent - first < PHASE_ITEMS) begin
      if (n_random < 530) begin
        src_idle_pct = 8;
        dst_idle_pct = 82;
      end else if (n_random < 1060) begin
        src_idle_pct = 82;
        dst_idle_pct = 8;
      end else begin
        src_idle_pct = 0;
        dst_idle_pct = 0;
      end
      if ($urandom_range(99) < 15) begin
        send_sample(1'($urandom_range(1)), $urandom_range(4095), $urandom_range(4095),
                    $urandom());
      end else begin
        play_stroke();
      end
      n_random = n_sent - PROBE_N;
    end
    drain();
  endtask

  always @(posedge clk) begin : result_check
    gesture_t want;
    cycles <= cycles + 1;
    m_axis_tready <= ($urandom_range(99) >= dst_idle_pct);
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (gesture_q.size() == 0) begin
        if (errors < 10) $display("unexpected gesture %0d at cycle %0d", m_axis_tdata, cycles);
        errors <= errors + 1;
      end else begin
        want = gesture_q.pop_front();
        if (m_axis_tdata !== {5'b0, want}) begin
          if (errors < 10)
            $display("gesture mismatch at cycle %0d: expected %0d, got %0d",
                     cycles, want, m_axis_tdata);
          errors <= errors + 1;
        end
      end
    end
  end

  initial begin : watchdog
    while (cycles < CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles, %0d gestures outstanding", cycles, gesture_q.size());
    $display("== FAIL ==");
    $finish;
  end

  initial begin : stimulus
    int i;
    probe_rows = '{
      '{1'b0, 12'd0, 12'd0, 32'd0, 1'b1, GEST_NONE},
      '{1'b1, 12'd2048, 12'd2048, 32'd1000, 1'b1, GEST_NONE},
      '{1'b0, 12'd2048, 12'd2048, 32'd1100, 1'b1, GEST_TAP},
      '{1'b1, 12'd2048, 12'd2048, 32'd1200, 1'b1, GEST_NONE},
      '{1'b0, 12'd2050, 12'd2046, 32'd1250, 1'b0, GEST_NONE},
      '{1'b1, 12'd2048, 12'd2048, 32'd1300, 1'b1, GEST_NONE},
      '{1'b0, 12'd2048, 12'd2048, 32'd1350, 1'b0, GEST_NONE},
      '{1'b1, 12'd0, 12'd0, 32'd2000, 1'b1, GEST_NONE},
      '{1'b0, 12'd4095, 12'd0, 32'd2010, 1'b1, GEST_RIGHT},
      '{1'b1, 12'd4095, 12'd4095, 32'd3000, 1'b1, GEST_NONE},
      '{1'b0, 12'd0, 12'd4095, 32'd3010, 1'b1, GEST_LEFT},
      '{1'b1, 12'd0, 12'd4095, 32'd4000, 1'b1, GEST_NONE},
      '{1'b0, 12'd0, 12'd0, 32'd4010, 1'b1, GEST_UP},
      '{1'b1, 12'd4095, 12'd0, 32'd5000, 1'b1, GEST_NONE},
      '{1'b0, 12'd4095, 12'd4095, 32'd5010, 1'b1, GEST_DOWN},
      '{1'b1, 12'd1000, 12'd1000, 32'd6000, 1'b1, GEST_NONE},
      // still touching: start point must not move
      '{1'b1, 12'd100, 12'd3000, 32'd6005, 1'b1, GEST_NONE},
      '{1'b0, 12'd2000, 12'd2000, 32'd6010, 1'b0, GEST_NONE},
      '{1'b0, 12'd2000, 12'd2000, 32'd6020, 1'b1, GEST_NONE},
      '{1'b1, 12'd0, 12'd0, 32'd7000, 1'b1, GEST_NONE},
      '{1'b0, 12'd500, 12'd0, 32'd7010, 1'b0, GEST_NONE},
      '{1'b1, 12'd100, 12'd100, 32'd8000, 1'b1, GEST_NONE},
      '{1'b0, 12'd100, 12'd100, 32'd8201, 1'b0, GEST_NONE},
      // press just before the timestamp wraps
      '{1'b1, 12'd3000, 12'd3000, 32'hFFFF_FFFF, 1'b1, GEST_NONE},
      '{1'b0, 12'd3000, 12'd3000, 32'h0000_0010, 1'b0, GEST_NONE},
      '{1'b1, 12'd3000, 12'd3000, 32'h0000_0020, 1'b1, GEST_NONE},
      '{1'b0, 12'd3000, 12'd3000, 32'h0000_00E8, 1'b0, GEST_NONE}
    };
    for (i = 0; i < 7; i++) gest_seen[i] = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (i = 0; i < PROBE_N; i++)
      send_sample(probe_rows[i].down, int'(probe_rows[i].x), int'(probe_rows[i].y),
                  probe_rows[i].t, probe_rows[i].typed, probe_rows[i].want);
    drain();

    run_phase(16'd0, 16'd0, 16'd0, 16'd0);
    run_phase(16'd4096, 16'd4096, 16'd65535, 16'd65535);
    run_phase(16'd300, 16'd300, 16'd50, 16'd100);
    // upper bits beyond the 13-bit distance field are dropped
    run_phase(16'hFFFF, 16'd8191, 16'd1, 16'd0);
    run_phase(16'd1, 16'd1, 16'd200, 16'd65535);
    run_phase(16'd1229, 16'd410, 16'd200, 16'd400);

    $display("ran %0d touch samples through the reset defaults and six register settings",
             n_sent);
    $display("gestures: none %0d, tap %0d, double %0d, left %0d, right %0d, up %0d, down %0d",
             gest_seen[0], gest_seen[1], gest_seen[2], gest_seen[3], gest_seen[4],
             gest_seen[5], gest_seen[6]);
    if (errors == 0 && gesture_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", errors);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
